[hdl/gchd_pkg.sv]
// Shared types, constants and CORDIC helpers for the great-circle distance unit.
// Depends on nothing; every other file in hdl/ imports it.
package gchd_pkg;

    // Internal angle and trig format: signed, 30 fraction bits
    localparam int IFRAC    = 30;
    localparam int STAGES   = 30;
    localparam int SQ_STEPS = 32;

    typedef logic signed [32:0] cord_t;
    typedef logic signed [31:0] trig_t;

    localparam cord_t ONE_C     = 33'sd1073741824;
    localparam cord_t GAIN_C    = 33'sd652032874;
    localparam cord_t HALF_PI_C = 33'sd1686629713;

    localparam logic [32:0] HALF_PI_U = 33'd1686629713;
    localparam logic [32:0] PI_U      = 33'd3373259426;
    localparam logic [32:0] TWO_PI_U  = 33'd6746518852;

    // Arctangent of 2^-i, Q.30
    function automatic cord_t atan_step(input int unsigned i);
        cord_t r;
        case (i)
            0:       r = 33'sd843314857;
            1:       r = 33'sd497837829;
            2:       r = 33'sd263043837;
            3:       r = 33'sd133525159;
            4:       r = 33'sd67021687;
            5:       r = 33'sd33543516;
            6:       r = 33'sd16775851;
            7:       r = 33'sd8388437;
            8:       r = 33'sd4194283;
            9:       r = 33'sd2097149;
            default: r = cord_t'(33'sd1 <<< (IFRAC - i));
        endcase
        return r;
    endfunction

    // Shift right, truncating toward zero
    function automatic cord_t tsh(input cord_t v, input int unsigned s);
        cord_t bias;
        bias = v[32] ? cord_t'((33'sd1 <<< s) - 33'sd1) : '0;
        return (v + bias) >>> s;
    endfunction

endpackage

[hdl/gchd_sincos.sv]
// Four-lane sine/cosine pipeline: modulo 2*pi reduction, quadrant fold, CORDIC rotation.
// Depends on gchd_pkg.
module gchd_sincos
    import gchd_pkg::*;
#(
    parameter int IW  = 33,
    parameter int RED = 1
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vld_i,
    input  logic signed [IW-1:0] ang_i [4],
    output logic                 vld_o,
    output trig_t                sin_o [4],
    output trig_t                cos_o [4]
);

    localparam int LANES = 4;
    localparam int MW    = IW - 1;
    localparam int DEPTH = RED + STAGES + 5;

    logic [MW-1:0] rm_reg  [LANES][RED+1];
    logic [MW-1:0] rm_next [LANES][RED+1];
    logic          rs_reg  [LANES][RED+1];
    logic          rs_next [LANES][RED+1];
    logic [31:0]   f1m_reg [LANES];
    logic [31:0]   f1m_next[LANES];
    logic          f1s_reg [LANES];
    logic          f1s_next[LANES];
    logic [30:0]   f2m_reg [LANES];
    logic [30:0]   f2m_next[LANES];
    logic          f2s_reg [LANES];
    logic          f2s_next[LANES];
    logic          f2c_reg [LANES];
    logic          f2c_next[LANES];
    cord_t         x_reg   [LANES][STAGES+1];
    cord_t         x_next  [LANES][STAGES+1];
    cord_t         y_reg   [LANES][STAGES+1];
    cord_t         y_next  [LANES][STAGES+1];
    cord_t         r_reg   [LANES][STAGES+1];
    cord_t         r_next  [LANES][STAGES+1];
    logic          nc_reg  [LANES][STAGES+1];
    logic          nc_next [LANES][STAGES+1];
    trig_t         sin_reg [LANES];
    trig_t         sin_next[LANES];
    trig_t         cos_reg [LANES];
    trig_t         cos_next[LANES];
    logic [DEPTH-1:0] vld_reg;

    // Multiple of 2*pi taken off in reduction step j
    function automatic logic [MW:0] step_val(input int j);
        return (MW+1)'(TWO_PI_U) << (RED - 1 - j);
    endfunction

    // Reduce, fold and rotate each lane
    always_comb
    begin
        logic [32:0] m33;
        cord_t       r0;
        cord_t       xc;
        cord_t       yc;
        for (int l = 0; l < LANES; l++)
        begin
            rs_next[l][0] = ang_i[l][IW-1];
            rm_next[l][0] = ang_i[l][IW-1] ? MW'(-ang_i[l]) : MW'(ang_i[l]);
            for (int j = 0; j < RED; j++)
            begin
                if ({1'b0, rm_reg[l][j]} >= step_val(j))
                    rm_next[l][j+1] = MW'({1'b0, rm_reg[l][j]} - step_val(j));
                else
                    rm_next[l][j+1] = rm_reg[l][j];
                rs_next[l][j+1] = rs_reg[l][j];
            end

            // Wrap into [-pi, pi]
            m33 = 33'(rm_reg[l][RED]);
            if (m33 > PI_U)
            begin
                f1m_next[l] = 32'(TWO_PI_U - m33);
                f1s_next[l] = !rs_reg[l][RED];
            end
            else
            begin
                f1m_next[l] = 32'(m33);
                f1s_next[l] = rs_reg[l][RED];
            end

            // Fold into [-pi/2, pi/2], cosine changes sign
            if ({1'b0, f1m_reg[l]} > HALF_PI_U)
            begin
                f2m_next[l] = 31'(PI_U - {1'b0, f1m_reg[l]});
                f2c_next[l] = 1'b1;
            end
            else
            begin
                f2m_next[l] = 31'(f1m_reg[l]);
                f2c_next[l] = 1'b0;
            end
            f2s_next[l] = f1s_reg[l];

            // CORDIC start, gain folded into x
            r0 = cord_t'({2'b00, f2m_reg[l]});
            r_next[l][0]  = f2s_reg[l] ? -r0 : r0;
            x_next[l][0]  = GAIN_C;
            y_next[l][0]  = '0;
            nc_next[l][0] = f2c_reg[l];

            for (int i = 0; i < STAGES; i++)
            begin
                if (!r_reg[l][i][32])
                begin
                    x_next[l][i+1] = x_reg[l][i] - tsh(y_reg[l][i], i);
                    y_next[l][i+1] = y_reg[l][i] + tsh(x_reg[l][i], i);
                    r_next[l][i+1] = r_reg[l][i] - atan_step(i);
                end
                else
                begin
                    x_next[l][i+1] = x_reg[l][i] + tsh(y_reg[l][i], i);
                    y_next[l][i+1] = y_reg[l][i] - tsh(x_reg[l][i], i);
                    r_next[l][i+1] = r_reg[l][i] + atan_step(i);
                end
                nc_next[l][i+1] = nc_reg[l][i];
            end

            // Clamp to [-1, 1] and apply cosine sign
            xc = x_reg[l][STAGES];
            yc = y_reg[l][STAGES];
            if (xc > ONE_C)
                xc = ONE_C;
            else if (xc < -ONE_C)
                xc = -ONE_C;
            if (yc > ONE_C)
                yc = ONE_C;
            else if (yc < -ONE_C)
                yc = -ONE_C;
            sin_next[l] = trig_t'(yc);
            cos_next[l] = nc_reg[l][STAGES] ? trig_t'(-xc) : trig_t'(xc);
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rm_reg  <= rm_next;
            rs_reg  <= rs_next;
            f1m_reg <= f1m_next;
            f1s_reg <= f1s_next;
            f2m_reg <= f2m_next;
            f2s_reg <= f2s_next;
            f2c_reg <= f2c_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            r_reg   <= r_next;
            nc_reg  <= nc_next;
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], vld_i};
    end

    assign vld_o = vld_reg[DEPTH-1];
    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

[hdl/gchd_sqrt.sv]
// Two-lane pipelined integer square root of (value * 2^30), one result bit per stage.
// Depends on gchd_pkg.
module gchd_sqrt
    import gchd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        vld_i,
    input  logic [30:0] val_i  [2],
    output logic        vld_o,
    output logic [30:0] root_o [2]
);

    localparam int DEPTH = SQ_STEPS + 1;

    logic [60:0] n_reg  [2][SQ_STEPS+1];
    logic [60:0] n_next [2][SQ_STEPS+1];
    logic [62:0] r_reg  [2][SQ_STEPS+1];
    logic [62:0] r_next [2][SQ_STEPS+1];
    logic [DEPTH-1:0] vld_reg;

    // One restoring step per stage
    always_comb
    begin
        logic [62:0] bitv;
        logic [62:0] trial;
        for (int l = 0; l < 2; l++)
        begin
            n_next[l][0] = {val_i[l], 30'd0};
            r_next[l][0] = '0;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                bitv  = 63'd1 << (62 - 2 * k);
                trial = r_reg[l][k] + bitv;
                if ({2'b00, n_reg[l][k]} >= trial)
                begin
                    n_next[l][k+1] = 61'({2'b00, n_reg[l][k]} - trial);
                    r_next[l][k+1] = (r_reg[l][k] >> 1) + bitv;
                end
                else
                begin
                    n_next[l][k+1] = n_reg[l][k];
                    r_next[l][k+1] = r_reg[l][k] >> 1;
                end
            end
            root_o[l] = 31'(r_reg[l][SQ_STEPS]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_next;
            r_reg <= r_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], vld_i};
    end

    assign vld_o = vld_reg[DEPTH-1];

endmodule

[hdl/gchd_atan2.sv]
// Pipelined CORDIC vectoring atan2 for a first-quadrant vector, result in [0, pi/2].
// Depends on gchd_pkg.
module gchd_atan2
    import gchd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        vld_i,
    input  logic [30:0] y_i,
    input  logic [30:0] x_i,
    output logic        vld_o,
    output logic [30:0] ang_o
);

    localparam int DEPTH = STAGES + 2;

    cord_t       x_reg  [STAGES+1];
    cord_t       x_next [STAGES+1];
    cord_t       y_reg  [STAGES+1];
    cord_t       y_next [STAGES+1];
    cord_t       z_reg  [STAGES+1];
    cord_t       z_next [STAGES+1];
    logic        zf_reg [STAGES+1];
    logic        zf_next[STAGES+1];
    logic [30:0] ang_reg;
    logic [30:0] ang_next;
    logic [DEPTH-1:0] vld_reg;

    // Rotate towards the x axis, accumulate the angle
    always_comb
    begin
        x_next[0]  = cord_t'({2'b00, x_i});
        y_next[0]  = cord_t'({2'b00, y_i});
        z_next[0]  = '0;
        zf_next[0] = (x_i == '0) && (y_i == '0);
        for (int i = 0; i < STAGES; i++)
        begin
            if (!y_reg[i][32] && (y_reg[i] != '0))
            begin
                x_next[i+1] = x_reg[i] + tsh(y_reg[i], i);
                y_next[i+1] = y_reg[i] - tsh(x_reg[i], i);
                z_next[i+1] = z_reg[i] + atan_step(i);
            end
            else
            begin
                x_next[i+1] = x_reg[i] - tsh(y_reg[i], i);
                y_next[i+1] = y_reg[i] + tsh(x_reg[i], i);
                z_next[i+1] = z_reg[i] - atan_step(i);
            end
            zf_next[i+1] = zf_reg[i];
        end

        // Zero vector gives zero; clamp to [0, pi/2]
        if (zf_reg[STAGES] || z_reg[STAGES][32])
            ang_next = '0;
        else if (z_reg[STAGES] > HALF_PI_C)
            ang_next = 31'(HALF_PI_C);
        else
            ang_next = 31'(z_reg[STAGES]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            zf_reg  <= zf_next;
            ang_reg <= ang_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], vld_i};
    end

    assign vld_o = vld_reg[DEPTH-1];
    assign ang_o = ang_reg;

endmodule

[hdl/great_circle_haversine_distance_unit.sv]
// Great-circle central angle (haversine formula), one point pair per cycle unless stalled.
// Depends on gchd_pkg, gchd_sincos, gchd_sqrt and gchd_atan2.
//
// Slave channel s_*: one transaction carries lat_a, lon_a, lat_b, lon_b in radians,
// signed, ANGLE_FRAC_BITS fraction bits. Master channel m_*: one transaction per
// input carrying the central angle (0 .. pi), unsigned, same fraction bits,
// saturated at 2^30 - 1.
// Every stage of the pipeline is a register with a valid bit; a new pair may be
// taken in every cycle, so throughput is one transaction per clock.
// The pipeline runs through the modulo 2*pi reduction steps, the 30 CORDIC rotation
// stages, the 32-stage square root and the 30 CORDIC vectoring stages.
// The output register holds a result until m_tready; while it is full and not
// taken, the whole pipeline holds and s_tready is low, so nothing is lost or repeated.
// Reset (rst_n low) clears all valid bits; the data registers are not reset.
module great_circle_haversine_distance_unit
    import gchd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 28
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // lat_a[29:0], lon_a[60:30], lat_b[90:61], lon_b[121:91]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata    // central_angle[29:0]
);

    localparam int LSH = (ANGLE_FRAC_BITS < IFRAC) ? IFRAC - ANGLE_FRAC_BITS : 0;
    localparam int RSH = (ANGLE_FRAC_BITS > IFRAC) ? ANGLE_FRAC_BITS - IFRAC : 0;
    localparam int IW  = 33 + LSH;
    localparam int RED = (LSH > 0) ? LSH : 1;
    localparam int OW  = 32 + RSH;
    localparam longint RHALF = (64'sd1 <<< RSH) >>> 1;
    localparam longint LHALF = (64'sd1 <<< LSH) >>> 1;
    localparam logic [29:0] OUT_MAX = 30'h3FFF_FFFF;

    logic en;

    logic signed [29:0] lat_a;
    logic signed [30:0] lon_a;
    logic signed [29:0] lat_b;
    logic signed [30:0] lon_b;

    logic signed [IW-1:0] la_reg, oa_reg, lb_reg, ob_reg;
    logic signed [IW-1:0] ang_reg [4];
    logic signed [IW-1:0] ang_next[4];
    logic [1:0] front_vld_reg;

    logic  sc_vld;
    trig_t sin_w [4];
    trig_t cos_w [4];

    logic signed [63:0] p_s1_reg, p_s2_reg, p_cc_reg, p2_reg;
    trig_t qs1_reg, qs2_reg, qcc_reg, qs1b_reg, qs1c_reg, q2_reg;
    logic [30:0] a_reg, a6_reg, om_reg;
    logic signed [32:0] a_sum;
    logic [5:0] mid_vld_reg;

    logic        sq_vld;
    logic [30:0] sq_in [2];
    logic [30:0] root_w [2];
    logic        at_vld;
    logic [30:0] half_ang;

    logic [OW-1:0] o_ext;
    logic [OW-1:0] o_scaled;
    logic [29:0]   out_next;
    logic [29:0]   out_reg;
    logic          m_valid_reg;

    // Port angle to internal Q.30, rounding half away from zero when narrowing
    function automatic logic signed [IW-1:0] cvt(input logic signed [30:0] v);
        logic signed [IW-1:0] w;
        w = IW'(v) <<< LSH;
        if (RSH > 0)
            w = (w + IW'(v[30] ? RHALF - 64'sd1 : RHALF)) >>> RSH;
        return w;
    endfunction

    // Half difference, rounded half away from zero
    function automatic logic signed [IW-1:0] half_diff(input logic signed [IW-1:0] b,
                                                       input logic signed [IW-1:0] a);
        logic signed [IW:0] d;
        d = (IW+1)'(b) - (IW+1)'(a);
        d = (d + (IW+1)'(!d[IW])) >>> 1;
        return IW'(d);
    endfunction

    // Q.30 product back to Q.30, rounded half away from zero
    function automatic trig_t rnd_q(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + (p[63] ? 64'sd536870911 : 64'sd536870912)) >>> IFRAC;
        return trig_t'(r);
    endfunction

    function automatic logic signed [63:0] mul_q(input trig_t a, input trig_t b);
        logic signed [63:0] r;
        r = a * b;
        return r;
    endfunction

    // Whole pipeline moves when the output register is empty or being taken
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    assign lat_a = s_tdata[29:0];
    assign lon_a = s_tdata[60:30];
    assign lat_b = s_tdata[90:61];
    assign lon_b = s_tdata[121:91];

    // Half differences and both latitudes for the sine/cosine lanes
    always_comb
    begin
        ang_next[0] = half_diff(lb_reg, la_reg);
        ang_next[1] = half_diff(ob_reg, oa_reg);
        ang_next[2] = la_reg;
        ang_next[3] = lb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            la_reg  <= cvt(31'(lat_a));
            oa_reg  <= cvt(lon_a);
            lb_reg  <= cvt(31'(lat_b));
            ob_reg  <= cvt(lon_b);
            ang_reg <= ang_next;
        end
    end

    gchd_sincos #(
        .IW  (IW),
        .RED (RED)
    ) u_sincos (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vld_i (front_vld_reg[1]),
        .ang_i (ang_reg),
        .vld_o (sc_vld),
        .sin_o (sin_w),
        .cos_o (cos_w)
    );

    // Combine: A = s1^2 + ca*cb*s2^2, clamped to [0, 1]
    assign a_sum = 33'(qs1c_reg) + 33'(q2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_s1_reg <= mul_q(sin_w[0], sin_w[0]);
            p_s2_reg <= mul_q(sin_w[1], sin_w[1]);
            p_cc_reg <= mul_q(cos_w[2], cos_w[3]);
            qs1_reg  <= rnd_q(p_s1_reg);
            qs2_reg  <= rnd_q(p_s2_reg);
            qcc_reg  <= rnd_q(p_cc_reg);
            p2_reg   <= mul_q(qcc_reg, qs2_reg);
            qs1b_reg <= qs1_reg;
            q2_reg   <= rnd_q(p2_reg);
            qs1c_reg <= qs1b_reg;
            if (a_sum[32])
                a_reg <= '0;
            else if (a_sum > ONE_C)
                a_reg <= 31'(ONE_C);
            else
                a_reg <= 31'(a_sum);
            a6_reg   <= a_reg;
            om_reg   <= 31'(ONE_C) - a_reg;
        end
    end

    assign sq_in[0] = a6_reg;
    assign sq_in[1] = om_reg;

    gchd_sqrt u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vld_i  (mid_vld_reg[5]),
        .val_i  (sq_in),
        .vld_o  (sq_vld),
        .root_o (root_w)
    );

    gchd_atan2 u_atan2 (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vld_i (sq_vld),
        .y_i   (root_w[0]),
        .x_i   (root_w[1]),
        .vld_o (at_vld),
        .ang_o (half_ang)
    );

    // Double, scale to port format and saturate
    always_comb
    begin
        o_ext = OW'({half_ang, 1'b0});
        if (RSH > 0)
            o_scaled = o_ext << RSH;
        else
            o_scaled = (o_ext + OW'(LHALF)) >> LSH;
        out_next = (o_scaled > OW'(OUT_MAX)) ? OUT_MAX : 30'(o_scaled);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= '0;
            mid_vld_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            front_vld_reg <= {front_vld_reg[0], s_tvalid};
            mid_vld_reg   <= {mid_vld_reg[4:0], sc_vld};
            m_valid_reg   <= at_vld;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

    // Stalled pipeline keeps its occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(mid_vld_reg) && $stable(front_vld_reg))
        else $error("pipeline valid bits moved during stall");

    // A and 1 - A handed to the square roots sum to one
    assert property (@(posedge clk) disable iff (!rst_n)
        mid_vld_reg[5] |-> (32'(a6_reg) + 32'(om_reg)) == 32'(ONE_C))
        else $error("A and 1-A inconsistent");

    // Result stays within its field
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:30] == 2'b00)
        else $error("result padding bits set");

endmodule

[dv/tb_great_circle_haversine_distance_unit.sv]
// Self-checking testbench for great_circle_haversine_distance_unit: random and corner
// point pairs are streamed in, each result is predicted in SV and compared in order.
// Depends on gchd_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_great_circle_haversine_distance_unit;
    import gchd_pkg::*;

    localparam int     AFB      = 28;
    localparam longint LAT_MAX  = 421657428;
    localparam longint LON_MAX  = 843314857;
    localparam longint Q_ONE    = 64'sd1073741824;
    localparam longint Q_PI     = 64'sd3373259426;
    localparam longint Q_HPI    = 64'sd1686629713;
    localparam longint Q_2PI    = 64'sd6746518852;
    localparam longint Q_GAIN   = 64'sd652032874;
    localparam longint ANG_SAT  = (64'sd1 << 30) - 1;
    localparam int     NRAND    = 1200;

    typedef struct packed {
        logic signed [30:0] lon_b;
        logic signed [29:0] lat_b;
        logic signed [30:0] lon_a;
        logic signed [29:0] lat_a;
    } pair_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // lat_a[29:0], lon_a[60:30], lat_b[90:61], lon_b[121:91]
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;   // central_angle[29:0]

    pair_t       pending_pairs[$];
    logic [29:0] expected_angles[$];
    int          mismatches;
    bit          stimulus_done;
    int          gap_left;
    int          burst_left;
    int          hold_off;
    int          hold_cycles;

    great_circle_haversine_distance_unit #(.ANGLE_FRAC_BITS(AFB)) dut (.*);

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Angle arithmetic
    function automatic longint trunc_shr(longint v, int s);
        if (v < 0)
            return -((-v) >>> s);
        return v >>> s;
    endfunction

    function automatic longint round_shr(longint v, int s);
        longint mag;
        if (s == 0)
            return v;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 << (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_shr(a * b, 30);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint arc_step(int i);
        return longint'(atan_step(i));
    endfunction

    // Rotate the gain vector by the angle after folding into [-pi/2, pi/2]
    task automatic rotate_angle(input longint ang, output longint sn, output longint cs);
        longint r, x, y, nx;
        bit     flip;
        r    = ang % Q_2PI;
        x    = Q_GAIN;
        y    = 0;
        flip = 1'b0;
        if (r > Q_PI)
            r -= Q_2PI;
        if (r < -Q_PI)
            r += Q_2PI;
        if (r > Q_HPI)
        begin
            r    = Q_PI - r;
            flip = 1'b1;
        end
        else if (r < -Q_HPI)
        begin
            r    = -Q_PI - r;
            flip = 1'b1;
        end
        for (int i = 0; i < 30; i++)
        begin
            if (r >= 0)
            begin
                nx = x - trunc_shr(y, i);
                y  = y + trunc_shr(x, i);
                r -= arc_step(i);
            end
            else
            begin
                nx = x + trunc_shr(y, i);
                y  = y - trunc_shr(x, i);
                r += arc_step(i);
            end
            x = nx;
        end
        x  = clip(x, -Q_ONE, Q_ONE);
        sn = clip(y, -Q_ONE, Q_ONE);
        cs = flip ? -x : x;
    endtask

    function automatic longint root_q(longint v);
        longint unsigned n, res, b;
        n   = longint'(v) << 30;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n  -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, nx;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        for (int i = 0; i < 30; i++)
        begin
            if (y > 0)
            begin
                nx = x + trunc_shr(y, i);
                y  = y - trunc_shr(x, i);
                z += arc_step(i);
            end
            else
            begin
                nx = x - trunc_shr(y, i);
                y  = y + trunc_shr(x, i);
                z -= arc_step(i);
            end
            x = nx;
        end
        return clip(z, 0, Q_HPI);
    endfunction

    // Central angle of a point pair at port precision
    task automatic central_angle_of(input pair_t p, output logic [29:0] ang);
        longint la, oa, lb, ob, s1, c1, s2, c2, sa, ca, sb, cb, hav, z, res;
        la = longint'(p.lat_a) <<< (30 - AFB);
        oa = longint'(p.lon_a) <<< (30 - AFB);
        lb = longint'(p.lat_b) <<< (30 - AFB);
        ob = longint'(p.lon_b) <<< (30 - AFB);
        rotate_angle(round_shr(lb - la, 1), s1, c1);
        rotate_angle(round_shr(ob - oa, 1), s2, c2);
        rotate_angle(la, sa, ca);
        rotate_angle(lb, sb, cb);
        hav = qmul(s1, s1) + qmul(qmul(ca, cb), qmul(s2, s2));
        hav = clip(hav, 0, Q_ONE);
        z   = 2 * vector_angle(root_q(hav), root_q(Q_ONE - hav));
        res = round_shr(z, 30 - AFB);
        if (res > ANG_SAT)
            res = ANG_SAT;
        ang = res[29:0];
    endtask

    function automatic pair_t make_pair(longint la, longint oa, longint lb, longint ob);
        pair_t p;
        p.lat_a = la[29:0];
        p.lon_a = oa[30:0];
        p.lat_b = lb[29:0];
        p.lon_b = ob[30:0];
        return p;
    endfunction

    function automatic longint rand_in(longint lim);
        return longint'($urandom_range(2 * lim)) - lim;
    endfunction

    // Stimulus
    initial
    begin
        longint lat_pts[5];
        longint lon_pts[5];
        lat_pts = '{-LAT_MAX, -1, 0, 1, LAT_MAX};
        lon_pts = '{-LON_MAX, -1, 0, 1, LON_MAX};
        // corners: identical points, poles, antipodes, coincident zeros
        pending_pairs.push_back(make_pair(0, 0, 0, 0));
        pending_pairs.push_back(make_pair(LAT_MAX, 0, -LAT_MAX, 0));
        pending_pairs.push_back(make_pair(0, -LON_MAX, 0, LON_MAX));
        pending_pairs.push_back(make_pair(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX));
        pending_pairs.push_back(make_pair(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX));
        pending_pairs.push_back(make_pair(LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
        pending_pairs.push_back(make_pair(12345, 0, 12345, 1));
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 3; j++)
                pending_pairs.push_back(make_pair(lat_pts[i], lon_pts[j],
                                                  lat_pts[4 - i], lon_pts[4 - j]));
        for (int i = 0; i < NRAND; i++)
        begin
            if (i % 4 == 0)
                pending_pairs.push_back(make_pair(rand_in(LAT_MAX), rand_in(LON_MAX),
                                                  rand_in(LAT_MAX), rand_in(LON_MAX)));
            else if (i % 4 == 1)
            begin
                longint la, oa;
                la = rand_in(LAT_MAX);
                oa = rand_in(LON_MAX);
                pending_pairs.push_back(make_pair(la, oa,
                    clip(la + rand_in(4096), -LAT_MAX, LAT_MAX),
                    clip(oa + rand_in(4096), -LON_MAX, LON_MAX)));
            end
            else if (i % 4 == 2)
            begin
                longint la, oa;
                la = rand_in(LAT_MAX);
                oa = rand_in(LON_MAX);
                pending_pairs.push_back(make_pair(la, oa, -la, -oa));
            end
            else
                pending_pairs.push_back(make_pair(
                    (($urandom_range(1)) ? LAT_MAX : -LAT_MAX) - rand_in(256),
                    rand_in(LON_MAX), rand_in(LAT_MAX),
                    (($urandom_range(1)) ? LON_MAX : -LON_MAX) - rand_in(256)));
        end
    end

    // Reset, then wait for drain
    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (stimulus_done && expected_angles.size() == 0);
        repeat (150) @(posedge clk);
        if (mismatches == 0 && expected_angles.size() == 0)
            $display("great_circle_haversine_distance_unit regression: pass");
        else
            $display("great_circle_haversine_distance_unit regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("great_circle_haversine_distance_unit regression: fail");
        $finish;
    end

    // Driver: bursts with random gaps; predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        logic [29:0] ang;
        if (!rst_n)
        begin
            s_tvalid      <= 1'b0;
            s_tdata       <= '0;
            gap_left      <= 0;
            burst_left    <= 0;
            stimulus_done <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                central_angle_of(pair_t'(s_tdata[121:0]), ang);
                expected_angles.push_back(ang);
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_pairs.size() == 0)
                begin
                    s_tvalid      <= 1'b0;
                    stimulus_done <= 1'b1;
                end
                else
                begin
                    s_tdata  <= {6'd0, pending_pairs.pop_front()};
                    s_tvalid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(40, 1);
                        gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off once traffic is flowing
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            hold_off    <= 0;
            hold_cycles <= 0;
        end
        else
        begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == 400)
                hold_off <= 300;
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end
            else if (hold_cycles < 2000 || hold_cycles > 4000)
                m_tready <= ($urandom_range(3) != 0);
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge clk)
    begin
        logic [29:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_angles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result central_angle=%0d", m_tdata[29:0]);
            end
            else
            begin
                want = expected_angles.pop_front();
                if (m_tdata[29:0] !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("central_angle mismatch: expected %0d actual %0d",
                                 want, m_tdata[29:0]);
                end
            end
        end
    end

endmodule

[filelist.f]
hdl/gchd_pkg.sv
hdl/gchd_sincos.sv
hdl/gchd_sqrt.sv
hdl/gchd_atan2.sv
hdl/great_circle_haversine_distance_unit.sv
dv/tb_great_circle_haversine_distance_unit.sv
